// File: design/weighted_random_pick_assert.svh
// assertion macros for the weighted random pick block
`ifndef WEIGHTED_RANDOM_PICK_ASSERT_SVH
`define WEIGHTED_RANDOM_PICK_ASSERT_SVH

`ifndef SYNTHESIS
`define WRP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("wrp assertion failed");
`define WRP_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wrp assertion failed");
`else
`define WRP_ASSERT(lbl, clk, rstn, prop)
`define WRP_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

// File: design/wrp_pkg.sv
// shared constants, types and width helpers for the weighted random pick block
package wrp_pkg;

  localparam int MAX_ENTRIES_DEF = 64;

  localparam int IDX_W = 6;
  localparam int WGT_W = 16;
  localparam int RND_W = 31;
  localparam int TOT_W = 22;
  localparam int CNT_W = 7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_PICK  = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  function automatic int addr_w(int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic int total_w(int n);
    return $clog2(n * ((1 << WGT_W) - 1) + 1);
  endfunction

endpackage

// File: design/wrp_mem.sv
// weight table memory, one write port and one registered read port
module wrp_mem #(
  parameter int DEPTH = wrp_pkg::MAX_ENTRIES_DEF,
  parameter int AW    = wrp_pkg::addr_w(wrp_pkg::MAX_ENTRIES_DEF)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [wrp_pkg::WGT_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [wrp_pkg::WGT_W-1:0] rdata_o
);
  import wrp_pkg::*;

  logic [WGT_W-1:0] mem_q [DEPTH];
  logic [WGT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/wrp_alu.sv
// shared add and subtract unit with borrow flag
module wrp_alu #(
  parameter int W = wrp_pkg::total_w(wrp_pkg::MAX_ENTRIES_DEF) + 1
) (
  input  wrp_pkg::alu_op_e op_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  output logic [W-1:0]     res_o,
  output logic             borrow_o
);
  import wrp_pkg::*;

  logic [W:0] ext;

  always_comb begin
    unique case (op_i)
      ALU_ADD: ext = {1'b0, a_i} + {1'b0, b_i};
      ALU_SUB: ext = {1'b0, a_i} - {1'b0, b_i};
      default: ext = '0;
    endcase
  end

  assign res_o    = ext[W-1:0];
  assign borrow_o = ext[W];

endmodule

// File: design/wrp_ctrl.sv
// sequencer for table clear, weight writes, sum, modulo and scan
`include "weighted_random_pick_assert.svh"

module wrp_ctrl #(
  parameter int MAX_ENTRIES = wrp_pkg::MAX_ENTRIES_DEF,
  parameter int AW          = wrp_pkg::addr_w(wrp_pkg::MAX_ENTRIES_DEF),
  parameter int RW          = wrp_pkg::total_w(wrp_pkg::MAX_ENTRIES_DEF) + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation_i,
  input  logic [wrp_pkg::IDX_W-1:0] entry_index_i,
  input  logic [wrp_pkg::WGT_W-1:0] entry_weight_i,
  input  logic [wrp_pkg::RND_W-1:0] random_value_i,
  input  logic                      cfg_we_i,
  input  logic [wrp_pkg::CNT_W-1:0] cfg_data_i,
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [wrp_pkg::WGT_W-1:0] mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [wrp_pkg::WGT_W-1:0] mem_rdata_i,
  output wrp_pkg::alu_op_e          alu_op_o,
  output logic [RW-1:0]             alu_a_o,
  output logic [RW-1:0]             alu_b_o,
  input  logic [RW-1:0]             alu_res_i,
  input  logic                      alu_borrow_i,
  output logic                      result_valid_o,
  output logic [wrp_pkg::IDX_W-1:0] server_index_o,
  output logic [wrp_pkg::TOT_W-1:0] total_weight_o
);
  import wrp_pkg::*;

  localparam int TW  = RW - 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int DCW = $clog2(RND_W);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_SCAN
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CW-1:0]    n_q, n_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pidx_q, pidx_d;
  logic [TW-1:0]    acc_q, acc_d;
  logic [TW-1:0]    total_q, total_d;
  logic [TW-1:0]    rem_q, rem_d;
  logic [RND_W-1:0] rand_q, rand_d;
  logic [DCW-1:0]   dcnt_q, dcnt_d;
  logic             valid_q, valid_d;
  logic [IDX_W-1:0] sidx_q, sidx_d;

  logic          issue;
  logic          idx_ok;
  logic [RW-1:0] trial;

  assign idx_ok = 32'(entry_index_i) < MAX_ENTRIES;
  assign issue  = cnt_q < n_q;
  assign trial  = {rem_q, rand_q[RND_W-1]};

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    acc_d       = acc_q;
    total_d     = total_q;
    rem_d       = rem_q;
    rand_d      = rand_q;
    dcnt_d      = dcnt_q;
    valid_d     = 1'b0;
    sidx_d      = sidx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = AW'(entry_index_i);
    mem_wdata_o = entry_weight_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = cnt_q[AW-1:0];
    alu_op_o    = ALU_ADD;
    alu_a_o     = RW'(acc_q);
    alu_b_o     = RW'(mem_rdata_i);

    if (cfg_we_i) begin
      count_d = cfg_data_i;
    end

    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q[AW-1:0];
        mem_wdata_o = '0;
        if (cnt_q == CW'(MAX_ENTRIES - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (operation_i == OP_WRITE) begin
            mem_we_o = idx_ok;
          end else begin
            rand_d  = random_value_i;
            n_d     = (32'(count_q) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(count_q);
            cnt_d   = '0;
            acc_d   = '0;
            pend_d  = 1'b0;
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        mem_re_o = issue;
        pend_d   = issue;
        if (issue) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (pend_q) begin
          acc_d = alu_res_i[TW-1:0];
        end
        if (!issue && !pend_q) begin
          total_d = acc_q;
          if (acc_q == '0) begin
            sidx_d  = '0;
            valid_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            rem_d   = '0;
            dcnt_d  = DCW'(RND_W - 1);
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        alu_op_o = ALU_SUB;
        alu_a_o  = trial;
        alu_b_o  = RW'(total_q);
        rem_d    = alu_borrow_i ? trial[TW-1:0] : alu_res_i[TW-1:0];
        rand_d   = {rand_q[RND_W-2:0], 1'b0};
        if (dcnt_q == '0) begin
          cnt_d   = '0;
          pend_d  = 1'b0;
          state_d = ST_SCAN;
        end else begin
          dcnt_d = dcnt_q - DCW'(1);
        end
      end
      ST_SCAN: begin
        mem_re_o = issue;
        pend_d   = issue;
        alu_op_o = ALU_SUB;
        alu_a_o  = RW'(rem_q);
        alu_b_o  = RW'(mem_rdata_i);
        if (issue) begin
          cnt_d  = cnt_q + CW'(1);
          pidx_d = cnt_q[AW-1:0];
        end
        if (pend_q) begin
          if (alu_borrow_i) begin
            sidx_d  = IDX_W'(pidx_q);
            valid_d = 1'b1;
            state_d = ST_IDLE;
          end else begin
            rem_d = alu_res_i[TW-1:0];
          end
        end else if (!issue) begin
          sidx_d  = '0;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      count_q <= '0;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
      n_q     <= '0;
      pidx_q  <= '0;
      acc_q   <= '0;
      total_q <= '0;
      rem_q   <= '0;
      rand_q  <= '0;
      dcnt_q  <= '0;
      sidx_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      n_q     <= n_d;
      pidx_q  <= pidx_d;
      acc_q   <= acc_d;
      total_q <= total_d;
      rem_q   <= rem_d;
      rand_q  <= rand_d;
      dcnt_q  <= dcnt_d;
      sidx_q  <= sidx_d;
    end
  end

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = valid_q;
  assign server_index_o = sidx_q;
  assign total_weight_o = TOT_W'(total_q);

  `WRP_ASSERT(a_strobe_single, clk_i, rst_ni, valid_q |=> !valid_q)
  `WRP_ASSERT(a_zero_total_index, clk_i, rst_ni, (valid_q && total_q == '0) |-> sidx_q == '0)
  `WRP_ASSERT(a_pick_goes_busy, clk_i, rst_ni, (start && !busy && operation_i == OP_PICK) |=> busy)
  `WRP_ASSERT(a_rem_below_total, clk_i, rst_ni, (state_q == ST_DIV) |-> rem_q < total_q)

endmodule

// File: design/weighted_random_pick.sv
// weighted random pick top level: table of weights, pick by random rank
// Transactions are accepted when start is high and busy is low. A write stores one
// weight and returns nothing. In a pick over the N active entries, the weights are
// summed one per cycle through the single read port of the table, the random value
// is reduced modulo the total one bit per cycle on the shared subtractor (31 steps),
// and the entries are scanned again one per cycle; a zero total returns index 0
// without the modulo and scan. The result shows for exactly one cycle on
// result_valid_o and cannot be stalled, so it must be captured then. After reset the
// table is cleared one entry per cycle with busy high; server_count writes are
// taken at any time.
module weighted_random_pick #(
  parameter int MAX_ENTRIES = wrp_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation_i,
  input  logic [wrp_pkg::IDX_W-1:0] entry_index_i,
  input  logic [wrp_pkg::WGT_W-1:0] entry_weight_i,
  input  logic [wrp_pkg::RND_W-1:0] random_value_i,
  input  logic                      cfg_we_i,
  input  logic [wrp_pkg::CNT_W-1:0] cfg_data_i,
  output logic                      result_valid_o,
  output logic [wrp_pkg::IDX_W-1:0] server_index_o,
  output logic [wrp_pkg::TOT_W-1:0] total_weight_o
);
  import wrp_pkg::*;

  localparam int AW = addr_w(MAX_ENTRIES);
  localparam int RW = total_w(MAX_ENTRIES) + 1;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [WGT_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [WGT_W-1:0] mem_rdata;
  alu_op_e          alu_op;
  logic [RW-1:0]    alu_a;
  logic [RW-1:0]    alu_b;
  logic [RW-1:0]    alu_res;
  logic             alu_borrow;

  wrp_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .AW         (AW),
    .RW         (RW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .entry_weight_i(entry_weight_i),
    .random_value_i(random_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_re_o      (mem_re),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .alu_op_o      (alu_op),
    .alu_a_o       (alu_a),
    .alu_b_o       (alu_b),
    .alu_res_i     (alu_res),
    .alu_borrow_i  (alu_borrow),
    .result_valid_o(result_valid_o),
    .server_index_o(server_index_o),
    .total_weight_o(total_weight_o)
  );

  wrp_mem #(
    .DEPTH(MAX_ENTRIES),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  wrp_alu #(
    .W(RW)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .res_o   (alu_res),
    .borrow_o(alu_borrow)
  );

endmodule

// File: verif/tb_weighted_random_pick.sv
// self-checking testbench for the weighted random pick block
`timescale 1ns / 1ps

module tb_weighted_random_pick;
  import wrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned TAIL_CYCLES = 200;
  localparam int unsigned CFG_SETTLE  = 8;

  typedef struct packed {
    logic [IDX_W-1:0] server_index;
    logic [TOT_W-1:0] total_weight;
  } pick_result_t;

  class pick_scoreboard;
    logic [WGT_W-1:0] weights [MAX_ENTRIES_DEF];
    logic [CNT_W-1:0] server_count;
    pick_result_t     expected_picks [$];
    int unsigned      failures;

    function new();
      foreach (weights[i]) weights[i] = '0;
      server_count = '0;
      failures     = 0;
    endfunction

    function void set_server_count(logic [CNT_W-1:0] cnt);
      server_count = cnt;
    endfunction

    function int unsigned outstanding();
      return expected_picks.size();
    endfunction

    // weight write updates the table, a pick predicts one result
    function void note_transaction(logic op, logic [IDX_W-1:0] idx, logic [WGT_W-1:0] wgt,
                                   logic [RND_W-1:0] rnd);
      int unsigned     active;
      int unsigned     i;
      bit              found;
      longint unsigned total;
      longint unsigned rank;
      pick_result_t    res;
      if (op == OP_WRITE) begin
        weights[idx] = wgt;
        return;
      end
      active = (server_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : server_count;
      total  = 0;
      for (i = 0; i < active; i++) total += weights[i];
      res.server_index = '0;
      if (total != 0) begin
        rank  = longint'(rnd) % total;
        found = 1'b0;
        for (i = 0; i < active && !found; i++) begin
          if (rank < weights[i]) begin
            res.server_index = IDX_W'(i);
            found = 1'b1;
          end else begin
            rank -= weights[i];
          end
        end
      end
      res.total_weight = TOT_W'(total);
      expected_picks.push_back(res);
    endfunction

    function void check_result(logic [IDX_W-1:0] idx, logic [TOT_W-1:0] tot);
      pick_result_t want;
      if (expected_picks.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result: server_index %0d total_weight %0d", idx, tot);
        return;
      end
      want = expected_picks.pop_front();
      if (idx !== want.server_index || tot !== want.total_weight) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("pick mismatch: server_index exp %0d got %0d, total_weight exp %0d got %0d",
                   want.server_index, idx, want.total_weight, tot);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             operation_i;
  logic [IDX_W-1:0] entry_index_i;
  logic [WGT_W-1:0] entry_weight_i;
  logic [RND_W-1:0] random_value_i;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_data_i;
  logic             result_valid_o;
  logic [IDX_W-1:0] server_index_o;
  logic [TOT_W-1:0] total_weight_o;

  pick_scoreboard board;
  int unsigned    items_sent;
  int unsigned    sender_idle_pct;
  int unsigned    cycle_count;

  weighted_random_pick u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .entry_index_i  (entry_index_i),
    .entry_weight_i (entry_weight_i),
    .random_value_i (random_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .server_index_o (server_index_o),
    .total_weight_o (total_weight_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1)
      board.check_result(server_index_o, total_weight_o);
  end

  function automatic logic [WGT_W-1:0] rand_weight();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return WGT_W'($urandom_range(15));
      default: return WGT_W'($urandom);
    endcase
  endfunction

  function automatic logic [RND_W-1:0] rand_draw();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return RND_W'($urandom_range(255));
      default: return RND_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [WGT_W-1:0] wgt, input logic [RND_W-1:0] rnd);
    start          <= 1'b1;
    operation_i    <= op;
    entry_index_i  <= idx;
    entry_weight_i <= wgt;
    random_value_i <= rnd;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_transaction(op, idx, wgt, rnd);
    items_sent++;
  endtask

  task automatic sender_pause();
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  // register writes only once every pick has returned and the block has settled
  task automatic set_server_count(input int unsigned cnt);
    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= CNT_W'(cnt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_server_count(CNT_W'(cnt));
  endtask

  task automatic run_segment(input bit fill_table);
    int unsigned cnt;
    int unsigned n;
    int unsigned k;
    logic [IDX_W-1:0] idx;
    if (fill_table) begin
      cnt = 64;
    end else begin
      case ($urandom_range(9))
        0: cnt = 0;
        1: cnt = 64;
        2: cnt = $urandom_range(127, 65);
        3, 4: cnt = $urandom_range(64, 1);
        default: cnt = $urandom_range(8, 1);
      endcase
    end
    set_server_count(cnt);
    if (fill_table || (cnt >= 64 && $urandom_range(2) == 0)) begin
      for (k = 0; k < MAX_ENTRIES_DEF; k++) begin
        sender_pause();
        send_item(OP_WRITE, IDX_W'(k), ($urandom_range(3) != 0) ? '1 : rand_weight(),
                  RND_W'($urandom));
      end
    end
    n = $urandom_range(40, 20);
    repeat (n) begin
      sender_pause();
      if ($urandom_range(99) < 45) begin
        send_item(OP_PICK, IDX_W'($urandom), WGT_W'($urandom), rand_draw());
      end else begin
        if (cnt > 0 && cnt < 64 && $urandom_range(3) != 0)
          idx = IDX_W'($urandom_range(cnt - 1));
        else
          idx = IDX_W'($urandom_range(63));
        send_item(OP_WRITE, idx, rand_weight(), RND_W'($urandom));
      end
    end
  endtask

  task automatic run_phase(input int unsigned pct, input int unsigned quota);
    int unsigned goal;
    sender_idle_pct = pct;
    goal = items_sent + quota;
    run_segment(1'b1);
    while (items_sent < goal) run_segment(1'b0);
  endtask

  initial begin
    board           = new();
    items_sent      = 0;
    sender_idle_pct = 0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    operation_i     = OP_WRITE;
    entry_index_i   = '0;
    entry_weight_i  = '0;
    random_value_i  = '0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty count and zero total
    set_server_count(0);
    send_item(OP_PICK, '1, '1, '1);
    send_item(OP_WRITE, '0, '0, '1);
    send_item(OP_WRITE, '1, '1, '0);
    send_item(OP_WRITE, IDX_W'(1), WGT_W'(1), '1);
    send_item(OP_PICK, '0, '0, '1);
    // full table, draw extremes
    set_server_count(64);
    send_item(OP_PICK, '0, '0, '0);
    send_item(OP_PICK, '1, '1, '1);
    send_item(OP_PICK, IDX_W'(6'h2a), WGT_W'(16'h5555), RND_W'(31'h2aaaaaaa));
    // count beyond the table
    set_server_count(127);
    send_item(OP_PICK, IDX_W'(6'h15), WGT_W'(16'haaaa), RND_W'(31'h55555555));
    // single entry with zero weight, then rank on an entry boundary
    set_server_count(1);
    send_item(OP_PICK, '0, '0, RND_W'(12345));
    send_item(OP_WRITE, '0, WGT_W'(16'h8000), '0);
    send_item(OP_PICK, '0, '0, '1);
    set_server_count(2);
    send_item(OP_PICK, '0, '0, RND_W'(32768));
    send_item(OP_PICK, '0, '0, RND_W'(32767));

    run_phase(30, 430);
    run_phase(87, 430);
    run_phase(0, 430);

    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.failures == 0 && board.outstanding() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/wrp_pkg.sv
design/wrp_mem.sv
design/wrp_alu.sv
design/wrp_ctrl.sv
design/weighted_random_pick.sv
verif/tb_weighted_random_pick.sv
